>>> rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Constants shared by the sine/cosine polynomial unit: fixed-point format,
// pi constants and the odd-polynomial coefficients, all with 30 fraction bits.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int FRAC_BITS = 30;

  localparam logic signed [31:0] K_HALF_PI = 32'sd1686629713;
  localparam logic signed [33:0] K_PI      = 34'sd3373259426;
  localparam logic signed [33:0] K_TWO_PI  = 34'sd6746518852;
  localparam logic        [27:0] K_INV_2PI = 28'd170891319;
  localparam logic signed [31:0] K_ONE     = 32'sd1073741824;

  localparam logic signed [31:0] K_C1 = -32'sd178956970;
  localparam logic signed [31:0] K_C2 = 32'sd8947847;
  localparam logic signed [31:0] K_C3 = -32'sd213040;
  localparam logic signed [31:0] K_C4 = 32'sd2956;

  localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

endpackage

>>> rtl/scp_ifs.sv
// ----------------------------------------------------------------------------
// scp_ifs
// Valid/ready channels of the sine/cosine unit: angle request and result.
// ----------------------------------------------------------------------------
interface scp_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] angle;

  modport source (output valid, output func, output angle, input ready);
  modport sink   (input valid, input func, input angle, output ready);
endinterface

interface scp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/scp_fxmul.sv
// ----------------------------------------------------------------------------
// scp_fxmul
// Pipelined Q.30 multiply, rounded to nearest with ties away from zero.
// Four register stages: magnitudes, product, rounding, sign.
// ----------------------------------------------------------------------------
module scp_fxmul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int RW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [RW-1:0] y
);
  import scp_pkg::*;

  localparam int PW = AW + BW;
  localparam int MW = PW - FRAC_BITS + 1;
  localparam logic [PW:0] RND = (PW + 1)'(1) << (FRAC_BITS - 1);

  logic                 neg1;
  logic        [AW-1:0] ma;
  logic        [BW-1:0] mb;
  logic                 neg2;
  logic        [PW-1:0] prod;
  logic                 neg3;
  logic        [MW-1:0] mag3;
  logic          [PW:0] rsum;
  logic signed [RW-1:0] res;

  assign rsum = {1'b0, prod} + RND;
  assign res  = $signed({1'b0, mag3[RW-2:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[AW-1] ^ b[BW-1];
      ma   <= a[AW-1] ? AW'(-a) : AW'(a);
      mb   <= b[BW-1] ? BW'(-b) : BW'(b);
      neg2 <= neg1;
      prod <= PW'(ma) * PW'(mb);
      neg3 <= neg2;
      mag3 <= rsum[PW:FRAC_BITS];
      y    <= neg3 ? -res : res;
    end
  end

endmodule

>>> rtl/sine_cosine_polynomial_unit.sv
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_unit
// Sine or cosine of a Q8.24 angle: reduction by the nearest turn, fold into
// [-pi/2, pi/2], then r * P(r*r) by Horner's rule in Q2.30.
//
//   channel  | dir | payload                        | handshake
//   ---------+-----+--------------------------------+------------
//   operand  | in  | func (1b), angle (s32, Q8.24)  | valid/ready
//   result   | out | value (s32, Q2.30)             | valid/ready
//
// One item per cycle sustained while no held result stalls it; the pipeline is
// reduction and fold followed by six chained four-stage multipliers.
// Synchronous reset clears the valid line only.
// A held result freezes the whole pipeline; operand.ready drops in that cycle.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_unit (
  input  logic      clk,
  input  logic      rst,
  scp_req_if.sink   operand,
  scp_rsp_if.source result
);
  import scp_pkg::*;

  localparam int NSTG = 36;
  localparam int RDLY = 24;
  localparam int SDLY = 15;

  logic [NSTG-1:0] vld;
  logic            en;

  logic signed [38:0] ang_w;
  logic signed [38:0] x1, x2, x3, x4, x5;
  logic        [37:0] mag2;
  logic               neg2, neg3;
  logic        [35:0] hi3;
  logic        [59:0] lo3;
  logic        [36:0] ksum;
  logic         [6:0] kmag;
  logic signed  [7:0] k4;
  logic signed [41:0] kp5;
  logic signed [41:0] r6;
  logic signed [31:0] r7;
  logic signed [31:0] r_dly [RDLY];
  logic signed [32:0] s11;
  logic signed [32:0] s_dly [SDLY];
  logic signed [31:0] y15, y20, y25, y30;
  logic signed [31:0] p3, p2, p1, p0;
  logic signed [32:0] v35;
  logic signed [31:0] val36;

  assign en            = !(vld[NSTG-1] && !result.ready);
  assign operand.ready = en;
  assign result.valid  = vld[NSTG-1];
  assign result.value  = val36;

  assign ang_w = {operand.angle[31], operand.angle, 6'b0};
  assign ksum  = 37'(hi3) + 37'(lo3[59:30]);
  assign kmag  = ksum[36:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], operand.valid};
    end
  end

  // reduction and fold
  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= ang_w + (operand.func ? 39'(K_HALF_PI) : 39'sd0);
      neg2 <= x1[38];
      mag2 <= x1[38] ? 38'(-x1) : x1[37:0];
      x2   <= x1;
      // bias 2^59 lands above the 58-bit product, so no carry
      hi3  <= 36'(mag2[37:30]) * 36'(K_INV_2PI);
      lo3  <= 60'(58'(mag2[29:0]) * 58'(K_INV_2PI)) + (60'd1 << 59);
      neg3 <= neg2;
      x3   <= x2;
      k4   <= neg3 ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});
      x4   <= x3;
      kp5  <= 42'(k4) * 42'(K_TWO_PI);
      x5   <= x4;
      r6   <= 42'(x5) - kp5;
      priority if (r6 > 42'(K_HALF_PI)) begin
        r7 <= 32'(42'(K_PI) - r6);
      end else if (r6 < -42'(K_HALF_PI)) begin
        r7 <= 32'(-42'(K_PI) - r6);
      end else begin
        r7 <= 32'(r6);
      end
    end
  end

  // operand delay lines for the Horner steps and the final multiply
  always_ff @(posedge clk) begin
    if (en) begin
      r_dly[0] <= r7;
      for (int i = 1; i < RDLY; i++) begin
        r_dly[i] <= r_dly[i-1];
      end
      s_dly[0] <= s11;
      for (int i = 1; i < SDLY; i++) begin
        s_dly[i] <= s_dly[i-1];
      end
    end
  end

  scp_fxmul #(.AW(32), .BW(32), .RW(33)) u_sq (
    .clk(clk), .en(en), .a(r7), .b(r7), .y(s11)
  );

  scp_fxmul #(.AW(33), .BW(32), .RW(32)) u_h3 (
    .clk(clk), .en(en), .a(s11), .b(K_C4), .y(y15)
  );

  scp_fxmul #(.AW(33), .BW(32), .RW(32)) u_h2 (
    .clk(clk), .en(en), .a(s_dly[4]), .b(p3), .y(y20)
  );

  scp_fxmul #(.AW(33), .BW(32), .RW(32)) u_h1 (
    .clk(clk), .en(en), .a(s_dly[9]), .b(p2), .y(y25)
  );

  scp_fxmul #(.AW(33), .BW(32), .RW(32)) u_h0 (
    .clk(clk), .en(en), .a(s_dly[14]), .b(p1), .y(y30)
  );

  scp_fxmul #(.AW(32), .BW(32), .RW(33)) u_val (
    .clk(clk), .en(en), .a(r_dly[RDLY-1]), .b(p0), .y(v35)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p3 <= K_C3 + y15;
      p2 <= K_C2 + y20;
      p1 <= K_C1 + y25;
      p0 <= K_ONE + y30;
      priority if (v35 > 33'(VALUE_MAX)) begin
        val36 <= VALUE_MAX;
      end else if (v35 < 33'(VALUE_MIN)) begin
        val36 <= VALUE_MIN;
      end else begin
        val36 <= 32'(v35);
      end
    end
  end

endmodule

>>> rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the sine/cosine unit, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker (
  input logic               clk,
  input logic               rst,
  input logic               operand_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [31:0] result_value
);
  import scp_pkg::*;

  localparam logic signed [31:0] BOUND = K_ONE + 32'sd1048576;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !operand_ready)
    else $error("operand taken while pipeline is stalled");

  a_free_flows: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> operand_ready)
    else $error("operand refused with empty output stage");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_value))
    else $error("stalled result changed");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_value <= BOUND && result_value >= -BOUND)
    else $error("result outside the unit range");

endmodule

bind sine_cosine_polynomial_unit scp_checker u_scp_checker (
  .clk          (clk),
  .rst          (rst),
  .operand_ready(operand.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_value (result.value)
);
